// ===== hdl/lkvc_pkg.sv =====
package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int VALUE_BITS = 64;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);
    localparam int KEY_BITS   = 32;
    localparam int CAP_BITS   = 5;

    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [VALUE_BITS-1:0] value_t;

    typedef enum logic [1:0] {
        ACT_PUT    = 2'd0,
        ACT_GET    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_WRITE = 2'd2
    } state_t;

    // Write command to the value memory.
    typedef struct packed {
        logic   we;
        idx_t   addr;
        value_t data;
    } vmem_wr_t;

endpackage

// ===== hdl/lkvc_value_ram.sv =====
module lkvc_value_ram
(
    input  logic                clk,
    input  lkvc_pkg::vmem_wr_t  wr,
    input  lkvc_pkg::idx_t      rd_addr,
    output lkvc_pkg::value_t    rd_data
);
    import lkvc_pkg::*;

    value_t mem [ENTRIES];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// Channel  | Ports                              | Handshake
// config   | capacity_we, capacity              | written when capacity_we is high
// request  | start, action, key, write_value    | taken when start high and busy low
// result   | done, hit, read_value              | one cycle, cannot be stalled
// A request passes through match and rank update, then the value memory
// read, then done. The registered memory read and the output hold register set this.
// Reset clears valid bits, ranks and count at once; keys and values need none.
// A result is shown for one cycle on done; the receiver cannot stall it.
module lru_key_value_cache
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        capacity_we,
    input  logic [4:0]                  capacity,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic signed [31:0]          key,
    input  logic [63:0]                 write_value,
    output logic                        done,
    output logic                        hit,
    output logic [63:0]                 read_value
);
    import lkvc_pkg::*;

    logic [CAP_BITS-1:0] cap_reg;
    state_t              state_reg, state_next;
    logic [ENTRIES-1:0]  valid_reg;
    logic [KEY_BITS-1:0] key_mem_reg [ENTRIES];
    idx_t                rank_reg [ENTRIES];
    cnt_t                count_reg;
    logic                hit_reg;
    logic                get_reg;
    value_t              rd_raw;
    vmem_wr_t            wr;
    idx_t                rd_addr;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_BITS'(16);
        else if (capacity_we)
            cap_reg <= capacity;
    end

    // Match logic on the incoming request.
    logic [ENTRIES-1:0] match;
    logic               found;
    idx_t               found_idx;
    idx_t               free_idx;
    logic               free_ok;
    idx_t               lru_idx;
    logic               lru_ok;
    cnt_t               eff_cap;
    always_comb
    begin
        found = 1'b0; found_idx = '0; free_ok = 1'b0; free_idx = '0;
        lru_ok = 1'b0; lru_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_mem_reg[i] == key);
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i]) begin found = 1'b1; found_idx = idx_t'(i); end
            if (!valid_reg[i]) begin free_ok = 1'b1; free_idx = idx_t'(i); end
            if (valid_reg[i] && ({1'b0, rank_reg[i]} == CNT_BITS'(count_reg - 1'b1)))
            begin
                lru_ok = 1'b1; lru_idx = idx_t'(i);
            end
        end
        if (cap_reg == '0)
            eff_cap = cnt_t'(1);
        else if (32'(cap_reg) > ENTRIES)
            eff_cap = cnt_t'(ENTRIES);
        else
            eff_cap = cnt_t'(cap_reg);
    end

    logic accept;
    assign accept = start && (state_reg == ST_IDLE);

    // Tag, valid, rank and count update in the accept cycle.
    logic               evict;
    idx_t               slot;
    always_comb
    begin
        evict = (count_reg >= eff_cap) && lru_ok;
        if (evict)
            slot = lru_idx;
        else
            slot = free_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) rank_reg[i] <= '0;
        end
        else if (accept)
        begin
            unique case (action_t'(action))
                ACT_PUT, ACT_GET:
                begin
                    if (found)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (valid_reg[i] && rank_reg[i] < rank_reg[found_idx])
                                rank_reg[i] <= rank_reg[i] + 1'b1;
                        rank_reg[found_idx] <= '0;
                    end
                    else if (action_t'(action) == ACT_PUT && (evict || free_ok))
                    begin
                        // An insert takes the oldest slot on eviction, else a free one; all others age by one.
                        for (int i = 0; i < ENTRIES; i++)
                            if (valid_reg[i] && idx_t'(i) != slot)
                                rank_reg[i] <= rank_reg[i] + 1'b1;
                        rank_reg[slot]  <= '0;
                        valid_reg[slot] <= 1'b1;
                        if (!evict) count_reg <= count_reg + 1'b1;
                    end
                end
                ACT_REMOVE:
                begin
                    if (found)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (valid_reg[i] && rank_reg[i] > rank_reg[found_idx])
                                rank_reg[i] <= rank_reg[i] - 1'b1;
                        rank_reg[found_idx]  <= '0;
                        valid_reg[found_idx] <= 1'b0;
                        count_reg <= count_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Key store: written on insert only.
    always_ff @(posedge clk)
    begin
        if (accept && action_t'(action) == ACT_PUT && !found && (evict || free_ok))
            key_mem_reg[slot] <= key;
    end

    // Value memory write on any put, read for get.
    always_comb
    begin
        wr.we   = accept && action_t'(action) == ACT_PUT && (found || evict || free_ok);
        wr.addr = found ? found_idx : slot;
        wr.data = value_t'(write_value);
        rd_addr = found_idx;
    end

    lkvc_value_ram u_ram
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  state_next = accept ? ST_READ : ST_IDLE;
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg <= found && (action_t'(action) != ACT_NONE);
            get_reg <= found && (action_t'(action) == ACT_GET);
        end
    end

    value_t rd_hold_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            rd_hold_reg <= rd_raw;
    end

    // Result outputs.
    always_comb
    begin
        busy       = (state_reg != ST_IDLE);
        done       = (state_reg == ST_WRITE);
        hit        = done && hit_reg;
        read_value = (done && get_reg) ? 64'(rd_hold_reg) : 64'd0;
    end

endmodule
